// ===== sv/srx_pkg.sv =====
// ----------------------------------------------------------------------------
// srx_pkg
// Types and constants shared by the sync frame receiver modules.
// ----------------------------------------------------------------------------
package srx_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  localparam int NUM_CODES = 6;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_TYPE,
    PH_FIELD,
    PH_BORDER,
    PH_OBSTACLE,
    PH_PATH,
    PH_CHECK
  } phase_t;

  localparam logic [2:0] REC_SCALAR   = 3'd0;
  localparam logic [2:0] REC_BORDER   = 3'd1;
  localparam logic [2:0] REC_OBSTACLE = 3'd2;
  localparam logic [2:0] REC_PATH     = 3'd3;
  localparam logic [2:0] REC_END      = 3'd4;

  localparam logic [2:0] FK_MOVE  = 3'd0;
  localparam logic [2:0] FK_SCAN  = 3'd1;
  localparam logic [2:0] FK_EST   = 3'd2;
  localparam logic [2:0] FK_CUR   = 3'd3;
  localparam logic [2:0] FK_PATH  = 3'd4;
  localparam logic [2:0] FK_MOTOR = 3'd5;

  localparam logic [1:0] FIELD_TIME   = 2'd0;
  localparam logic [1:0] FIELD_FIRST  = 2'd1;
  localparam logic [1:0] FIELD_SECOND = 2'd2;
  localparam logic [1:0] FIELD_LAST   = 2'd3;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       sync1;
    logic       sync2;
    logic       type_hit;
    logic [2:0] type_idx;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [2:0]  frame_kind;
    logic [1:0]  field_number;
    logic [31:0] raw_value;
    logic [15:0] point_number;
    logic        frame_good;
    logic        last_of_frame;
  } rec_t;

endpackage

// ===== sv/srx_ifs.sv =====
// ----------------------------------------------------------------------------
// srx interfaces
// Byte input, record output and configuration write channels.
// ----------------------------------------------------------------------------
interface srx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface srx_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [2:0]  frame_kind;
  logic [1:0]  field_number;
  logic [31:0] raw_value;
  logic [15:0] point_number;
  logic        frame_good;
  logic        last_of_frame;
  modport source (output valid, output record_kind, output frame_kind,
                  output field_number, output raw_value, output point_number,
                  output frame_good, output last_of_frame, input ready);
  modport sink (input valid, input record_kind, input frame_kind,
                input field_number, input raw_value, input point_number,
                input frame_good, input last_of_frame, output ready);
endinterface

interface srx_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/sync_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// sync_frame_receiver_unit
// a record is registered after the byte that completes it leaves the queue
// throughput: 1 byte per cycle, set by the parser step, unless output stalls
// the byte queue lets input keep flowing while the output stalls, until full
// reset: synchronous; parser hunts for sync, queue and output empty,
// type codes return to 0..5
// ----------------------------------------------------------------------------
module sync_frame_receiver_unit import srx_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input logic      clk,
  input logic      rst,
  srx_byte_if.sink rx,
  srx_rec_if.source rec,
  srx_cfg_if.sink  cfg
);

  logic   push;
  logic   pop;
  entry_t wr_entry;
  entry_t head;
  qstat_t qstat;

  srx_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .cfg   (cfg),
    .qstat (qstat),
    .push  (push),
    .entry (wr_entry)
  );

  srx_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (head),
    .qstat   (qstat)
  );

  srx_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .rec   (rec)
  );

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty together");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    rec.valid && rec.last_of_frame |-> rec.record_kind == REC_END)
    else $error("frame end flag on non end record");

  a_good_only_end: assert property (@(posedge clk) disable iff (rst)
    rec.valid && rec.record_kind != REC_END |-> !rec.frame_good && !rec.last_of_frame)
    else $error("frame status on data record");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rec.valid)
    else $error("record valid right after reset");

endmodule

// ===== sv/srx_front.sv =====
// ----------------------------------------------------------------------------
// srx_front
// Holds the type code registers, accepts bytes and tags each one with its
// sync and type match before it enters the queue.
// ----------------------------------------------------------------------------
module srx_front import srx_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  srx_byte_if.sink     rx,
  srx_cfg_if.sink      cfg,
  input  qstat_t       qstat,
  output logic         push,
  output entry_t       entry
);

  logic [7:0] codes [NUM_CODES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        codes[i] <= 8'(i);
      end
    end else if (cfg.valid && cfg.ready && cfg.index < CFG_IDX_W'(NUM_CODES)) begin
      codes[cfg.index] <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;
  assign rx.ready  = !qstat.full;
  assign push      = rx.valid && rx.ready;

  // lowest matching code wins
  always_comb begin
    entry.data     = rx.rx_byte;
    entry.sync1    = rx.rx_byte == SYNC_FIRST;
    entry.sync2    = rx.rx_byte == SYNC_SECOND;
    entry.type_hit = 1'b0;
    entry.type_idx = FK_MOVE;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (codes[i] == rx.rx_byte) begin
        entry.type_hit = 1'b1;
        entry.type_idx = 3'(i);
      end
    end
  end

endmodule

// ===== sv/srx_fifo.sv =====
// ----------------------------------------------------------------------------
// srx_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module srx_fifo import srx_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_data,
  input  logic   pop,
  output entry_t rd_data,
  output qstat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_data     = mem[rd_ptr];
  assign qstat.full  = count == CW'(DEPTH);
  assign qstat.empty = count == '0;

endmodule

// ===== sv/srx_back.sv =====
// ----------------------------------------------------------------------------
// srx_back
// Frame parser: walks the frame layout byte by byte and drives the record
// output register.
// ----------------------------------------------------------------------------
module srx_back import srx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  qstat_t    qstat,
  output logic      pop,
  srx_rec_if.source rec
);

  phase_t      phase, phase_next;
  logic [7:0]  sum, sum_next;
  logic [2:0]  kind, kind_next;
  logic [1:0]  fc, fc_next;
  logic [1:0]  bc, bc_next;
  logic [31:0] acc, acc_next;
  logic [15:0] rem, rem_next;
  logic [15:0] pc, pc_next;

  logic        out_valid;
  rec_t        out_r;
  logic        emit;
  rec_t        emit_rec;

  logic [7:0]  sum_add;
  logic [31:0] fval;
  logic [15:0] pval;
  logic        fdone;

  assign pop = !qstat.empty && (!out_valid || rec.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
      sum   <= '0;
      kind  <= FK_MOVE;
      fc    <= FIELD_TIME;
      bc    <= '0;
      acc   <= '0;
      rem   <= '0;
      pc    <= '0;
    end else if (pop) begin
      phase <= phase_next;
      sum   <= sum_next;
      kind  <= kind_next;
      fc    <= fc_next;
      bc    <= bc_next;
      acc   <= acc_next;
      rem   <= rem_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    sum_add    = sum + head.data;
    fval       = acc | (32'(head.data) << {bc, 3'b000});
    pval       = acc[15:0] | (16'(head.data) << {bc[0], 3'b000});
    fdone      = (fc == FIELD_TIME) ? (bc == 2'd3) : (bc == 2'd1);
    phase_next = phase;
    sum_next   = sum;
    kind_next  = kind;
    fc_next    = fc;
    bc_next    = bc;
    acc_next   = acc;
    rem_next   = rem;
    pc_next    = pc;
    emit       = 1'b0;
    emit_rec   = '{record_kind: REC_SCALAR, frame_kind: kind, field_number: FIELD_TIME,
                   raw_value: 32'd0, point_number: 16'd0, frame_good: 1'b0,
                   last_of_frame: 1'b0};
    case (phase)
      PH_HUNT2: begin
        if (head.sync2) begin
          sum_next   = sum_add;
          phase_next = PH_TYPE;
        end else begin
          sum_next   = '0;
          phase_next = PH_HUNT1;
        end
      end
      PH_TYPE: begin
        if (head.type_hit) begin
          sum_next   = sum_add;
          kind_next  = head.type_idx;
          fc_next    = FIELD_TIME;
          bc_next    = '0;
          acc_next   = '0;
          phase_next = PH_FIELD;
        end else begin
          sum_next   = '0;
          phase_next = PH_HUNT1;
        end
      end
      PH_FIELD: begin
        sum_next = sum_add;
        if (!fdone) begin
          acc_next = fval;
          bc_next  = bc + 1'b1;
        end else begin
          emit                  = 1'b1;
          emit_rec.field_number = fc;
          emit_rec.raw_value    = fval;
          acc_next              = '0;
          bc_next               = '0;
          if ((kind == FK_SCAN && fc == FIELD_FIRST) ||
              (kind == FK_SCAN && fc == FIELD_SECOND) ||
              (kind == FK_PATH && fc == FIELD_FIRST)) begin
            rem_next = fval[15:0];
            pc_next  = '0;
            if (fval[15:0] != '0) begin
              if (kind == FK_PATH) begin
                phase_next = PH_PATH;
              end else if (fc == FIELD_FIRST) begin
                phase_next = PH_BORDER;
              end else begin
                phase_next = PH_OBSTACLE;
              end
            end else if (kind == FK_SCAN && fc == FIELD_FIRST) begin
              fc_next = FIELD_SECOND;
            end else begin
              phase_next = PH_CHECK;
            end
          end else if (fc == FIELD_LAST) begin
            phase_next = PH_CHECK;
          end else begin
            fc_next = fc + 1'b1;
          end
        end
      end
      PH_BORDER, PH_OBSTACLE, PH_PATH: begin
        sum_next = sum_add;
        if (!bc[0]) begin
          acc_next = {16'd0, pval};
          bc_next  = bc + 1'b1;
        end else begin
          emit                  = 1'b1;
          emit_rec.raw_value    = {16'd0, pval};
          emit_rec.point_number = pc;
          case (phase)
            PH_BORDER:   emit_rec.record_kind = REC_BORDER;
            PH_OBSTACLE: emit_rec.record_kind = REC_OBSTACLE;
            default:     emit_rec.record_kind = REC_PATH;
          endcase
          acc_next = '0;
          bc_next  = '0;
          pc_next  = pc + 1'b1;
          rem_next = rem - 1'b1;
          if (rem == 16'd1) begin
            if (phase == PH_BORDER) begin
              phase_next = PH_FIELD;
              fc_next    = FIELD_SECOND;
            end else begin
              phase_next = PH_CHECK;
            end
          end
        end
      end
      PH_CHECK: begin
        emit                   = 1'b1;
        emit_rec.record_kind   = REC_END;
        emit_rec.raw_value     = 32'(head.data);
        emit_rec.frame_good    = sum_add == '0;
        emit_rec.last_of_frame = 1'b1;
        sum_next               = '0;
        phase_next             = PH_HUNT1;
      end
      default: begin
        if (head.sync1) begin
          sum_next   = SYNC_FIRST;
          phase_next = PH_HUNT2;
        end else begin
          sum_next   = '0;
          phase_next = PH_HUNT1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (rec.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_r <= emit_rec;
    end
  end

  assign rec.valid         = out_valid;
  assign rec.record_kind   = out_r.record_kind;
  assign rec.frame_kind    = out_r.frame_kind;
  assign rec.field_number  = out_r.field_number;
  assign rec.raw_value     = out_r.raw_value;
  assign rec.point_number  = out_r.point_number;
  assign rec.frame_good    = out_r.frame_good;
  assign rec.last_of_frame = out_r.last_of_frame;

endmodule
